@@ rtl/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types, command and phase codes, and constants of the ADSR envelope
// generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Default number of voices held by the generator.
  localparam int VOICES_DEF = 8;

  // Command codes carried on the request channel.
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

  // Envelope phase codes.
  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_DECAY   = 2'd1;
  localparam logic [1:0] PH_SUSTAIN = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Envelope level limit and the attack step numerator.
  localparam logic [7:0] LEVEL_MAX  = 8'd255;
  localparam logic [8:0] ATTACK_NUM = 9'd256;

  // Shared divider operand widths.
  localparam int DIV_DVD_W = 9;
  localparam int DIV_DVS_W = 8;

  // Complete state of one voice.
  typedef struct packed {
    logic [7:0] level;
    logic [1:0] phase;
    logic       gate;
    logic       active;
    logic [7:0] attack;
    logic [7:0] decay;
    logic [7:0] sustain;
    logic [7:0] release_t;
  } voice_state_t;

endpackage

@@ rtl/adsr_div.sv @@
// ----------------------------------------------------------------------------
// adsr_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adsr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [adsr_pkg::DIV_DVD_W-1:0]  dividend,
  input  logic [adsr_pkg::DIV_DVS_W-1:0]  divisor,
  output logic                            busy,
  output logic                            done,
  output logic [adsr_pkg::DIV_DVD_W-1:0]  quotient
);

  localparam int DVD_W = adsr_pkg::DIV_DVD_W;
  localparam int DVS_W = adsr_pkg::DIV_DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  // The dividend shifts out of quo_r from the top while quotient bits enter
  // at the bottom.
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/adsr_vbank.sv @@
// ----------------------------------------------------------------------------
// adsr_vbank
// Per-voice envelope state with one read port, one write port and the
// active flags of all voices.
// ----------------------------------------------------------------------------
module adsr_vbank #(
  parameter int VOICES = adsr_pkg::VOICES_DEF,
  parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VW-1:0]          rd_addr,
  output adsr_pkg::voice_state_t rd_data,
  input  logic                   wr_en,
  input  logic [VW-1:0]          wr_addr,
  input  adsr_pkg::voice_state_t wr_data,
  output logic [VOICES-1:0]      active_vec
);

  adsr_pkg::voice_state_t mem_r [VOICES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = (int'(rd_addr) < VOICES) ? mem_r[rd_addr] : '0;

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      active_vec[i] = mem_r[i].active;
    end
  end

endmodule

@@ rtl/adsr_envelope_generator.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Multi-voice ADSR envelope generator stepped by a small sequencer around
// one shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel carries a command. A note on loads a voice's
// attack, decay, sustain and release times and restarts its envelope from
// level 0 in the attack phase. A note off drops the gate and forces release.
// Both return exactly one result for the addressed voice, with out_last set.
// A tick steps every active voice once, in ascending voice order, and
// returns one result per stepped voice; the final one carries out_last. A
// tick with no active voice, an unused command code, or a voice number
// beyond the voice count returns nothing.
// Timing: the block takes one request at a time and holds in_stall high
// until all of its results are taken. A note command is answered in the
// cycle after acceptance. During a tick each inactive voice only passes
// through a scan step, and each active voice passes through a scan step, a
// division in the shared divider where needed (one quotient bit per cycle),
// and the output, where its written-back result waits until it is taken.
// Sustain steps and zero times skip the divider.
// Reset clears every voice to idle, level 0, attack phase, all times zero.
// When the receiver stalls, the current result holds on the out_ ports and
// the sequencer waits; no voice is stepped until that result is taken.
// ----------------------------------------------------------------------------
module adsr_envelope_generator #(
  parameter int VOICES = adsr_pkg::VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [2:0] in_voice_sel,
  input  logic [7:0] in_attack_in,
  input  logic [7:0] in_decay_in,
  input  logic [7:0] in_sustain_in,
  input  logic [7:0] in_release_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_voice_out,
  output logic [7:0] out_level_out,
  output logic [1:0] out_phase_out,
  output logic       out_voice_active,
  output logic       out_last
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [VW-1:0] ptr_r, ptr_nxt;
  logic [2:0]    out_voice_r, out_voice_nxt;
  logic [7:0]    out_level_r, out_level_nxt;
  logic [1:0]    out_phase_r, out_phase_nxt;
  logic          out_active_r, out_active_nxt;
  logic          out_last_r, out_last_nxt;

  logic                   in_accept;
  logic [VW-1:0]          sel_idx;
  logic                   sel_ok;
  logic [VW-1:0]          rd_addr;
  adsr_pkg::voice_state_t rd;
  logic [VOICES-1:0]      active_vec;
  logic                   wr_en;
  logic [VW-1:0]          wr_addr;
  adsr_pkg::voice_state_t wr_data;

  logic                   div_start;
  logic [8:0]             div_dvd;
  logic [7:0]             div_dvs;
  logic                   div_busy;
  logic                   div_done;
  logic [8:0]             div_q;

  logic                   need_div;
  adsr_pkg::voice_state_t stepped;
  logic                   later_active;

  assign in_accept = in_valid && !in_stall;
  assign sel_idx   = VW'(in_voice_sel);
  assign sel_ok    = (int'(in_voice_sel) < VOICES);
  // The only read port follows the request in idle and the scan pointer
  // otherwise.
  assign rd_addr   = (state_r == S_IDLE) ? sel_idx : ptr_r;

  adsr_vbank #(
    .VOICES (VOICES),
    .VW     (VW)
  ) u_vbank (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (rd_addr),
    .rd_data    (rd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .active_vec (active_vec)
  );

  adsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Operands for the shared divider, chosen by the phase of the scanned voice.
  // The divider is only needed when the time is nonzero and, in decay, when
  // the level still sits above the sustain level.
  always_comb begin
    need_div = 1'b0;
    div_dvd  = {1'b0, rd.level};
    div_dvs  = rd.release_t;
    case (rd.phase)
      adsr_pkg::PH_ATTACK: begin
        need_div = (rd.attack != 8'd0);
        div_dvd  = adsr_pkg::ATTACK_NUM;
        div_dvs  = rd.attack;
      end
      adsr_pkg::PH_DECAY: begin
        need_div = (rd.decay != 8'd0) && (rd.level > rd.sustain);
        div_dvd  = {1'b0, rd.level - rd.sustain};
        div_dvs  = rd.decay;
      end
      adsr_pkg::PH_SUSTAIN: begin
        need_div = 1'b0;
      end
      default: begin
        need_div = (rd.release_t != 8'd0);
      end
    endcase
  end

  // One envelope step of the scanned voice. The quotient is only looked at
  // on the paths that asked for a division.
  always_comb begin
    logic [9:0] sum;
    logic [8:0] rate;
    logic [8:0] lower;
    stepped = rd;
    sum     = {2'b00, rd.level} + {1'b0, div_q};
    rate    = (div_q == 9'd0) ? 9'd1 : div_q;
    lower   = {1'b0, rd.level} - rate;
    case (rd.phase)
      adsr_pkg::PH_ATTACK: begin
        if (rd.attack == 8'd0 || sum >= {2'b00, adsr_pkg::LEVEL_MAX}) begin
          stepped.level = adsr_pkg::LEVEL_MAX;
          stepped.phase = adsr_pkg::PH_DECAY;
        end else begin
          stepped.level = sum[7:0];
        end
      end
      adsr_pkg::PH_DECAY: begin
        // A level at or under sustain always lands on sustain in one step.
        if (rd.decay == 8'd0 || rd.level <= rd.sustain ||
            lower <= {1'b0, rd.sustain}) begin
          stepped.level = rd.sustain;
          stepped.phase = adsr_pkg::PH_SUSTAIN;
        end else begin
          stepped.level = lower[7:0];
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        if (!rd.gate) begin
          stepped.phase = adsr_pkg::PH_RELEASE;
        end
      end
      default: begin
        if (rd.release_t == 8'd0 || {1'b0, rd.level} < rate) begin
          stepped.level = 8'd0;
        end else begin
          stepped.level = lower[7:0];
        end
      end
    endcase
    if (stepped.level == 8'd0 && stepped.phase == adsr_pkg::PH_RELEASE) begin
      stepped.active = 1'b0;
      stepped.gate   = 1'b0;
    end
  end

  // Any active voice above the pointer means the current result is not last.
  always_comb begin
    later_active = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      if (i > int'(ptr_r) && active_vec[i]) begin
        later_active = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    out_voice_nxt  = out_voice_r;
    out_level_nxt  = out_level_r;
    out_phase_nxt  = out_phase_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = stepped;
    div_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_cmd == adsr_pkg::CMD_TICK) begin
            ptr_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (sel_ok && (in_cmd == adsr_pkg::CMD_NOTE_ON ||
                                  in_cmd == adsr_pkg::CMD_NOTE_OFF)) begin
            wr_en   = 1'b1;
            wr_addr = sel_idx;
            wr_data = rd;
            if (in_cmd == adsr_pkg::CMD_NOTE_ON) begin
              wr_data.attack    = in_attack_in;
              wr_data.decay     = in_decay_in;
              wr_data.sustain   = in_sustain_in;
              wr_data.release_t = in_release_in;
              wr_data.level     = 8'd0;
              wr_data.phase     = adsr_pkg::PH_ATTACK;
              wr_data.gate      = 1'b1;
              wr_data.active    = 1'b1;
            end else begin
              wr_data.gate  = 1'b0;
              wr_data.phase = adsr_pkg::PH_RELEASE;
            end
            out_voice_nxt  = in_voice_sel;
            out_level_nxt  = wr_data.level;
            out_phase_nxt  = wr_data.phase;
            out_active_nxt = wr_data.active;
            out_last_nxt   = 1'b1;
            state_nxt      = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (!rd.active) begin
          if (ptr_r == LAST_VOICE) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else if (need_div) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          wr_en          = 1'b1;
          out_voice_nxt  = 3'(ptr_r);
          out_level_nxt  = stepped.level;
          out_phase_nxt  = stepped.phase;
          out_active_nxt = stepped.active;
          out_last_nxt   = !later_active;
          state_nxt      = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_en          = 1'b1;
          out_voice_nxt  = 3'(ptr_r);
          out_level_nxt  = stepped.level;
          out_phase_nxt  = stepped.phase;
          out_active_nxt = stepped.active;
          out_last_nxt   = !later_active;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ptr_r      <= '0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      out_last_r <= out_last_nxt;
    end
    out_voice_r  <= out_voice_nxt;
    out_level_r  <= out_level_nxt;
    out_phase_r  <= out_phase_nxt;
    out_active_r <= out_active_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_voice_out    = out_voice_r;
  assign out_level_out    = out_level_r;
  assign out_phase_out    = out_phase_r;
  assign out_voice_active = out_active_r;
  assign out_last         = out_last_r;

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside the divide state");

  // Taking the final result of a request frees the request channel.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (!out_valid && !in_stall))
    else $error("block not idle after last result");

  // A voice reported idle has always finished its release at level zero.
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_voice_active) |->
      (out_level_out == 8'd0 && out_phase_out == adsr_pkg::PH_RELEASE))
    else $error("idle voice reported with nonzero level or wrong phase");

endmodule

@@ dv/adsr_envelope_generator_tb.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_generator_tb
// Self-checking testbench for the multi-voice ADSR envelope generator. A
// queue of requests (directed corner cases, then random note sequences)
// feeds a clocked driver. An in-testbench envelope model predicts the voice
// reports of every accepted request, and a clocked monitor compares each
// report taken from the block with the oldest prediction. Sender gaps and
// receiver stalls vary in phases over the run.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICES      = adsr_pkg::VOICES_DEF;
  localparam int CLK_PERIOD  = 10;
  localparam int RESET_TICKS = 11;
  localparam int RANDOM_REQS = 175;
  // Cycles after the last report in which a stray report would still show.
  localparam int DRAIN_TICKS = 300;
  // Cycles with no handshake on either channel before the run is abandoned.
  // A tick keeps both channels quiet while the block works on a voice, and an
  // 85 percent stall or gap rate stretches single waits further.
  localparam int STUCK_LIMIT = 3000;
  // Number of accepted requests spent in each idling mode.
  localparam int MODE_SPAN   = 40;

  // The package names three commands; code 3 is unused and must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Idling modes, cycled through as requests are accepted.
  localparam int MODE_NONE   = 0;
  localparam int MODE_SENDER = 1;
  localparam int MODE_RECV   = 2;
  localparam int MODE_BOTH   = 3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] voice;
    logic [7:0] attack;
    logic [7:0] decay;
    logic [7:0] sustain;
    logic [7:0] rel_time;
  } env_request_t;

  typedef struct packed {
    logic [2:0] voice;
    logic [7:0] level;
    logic [1:0] phase;
    logic       active;
    logic       last;
  } voice_report_t;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd           = adsr_pkg::CMD_TICK;
  logic [2:0] in_voice_sel     = '0;
  logic [7:0] in_attack_in     = '0;
  logic [7:0] in_decay_in      = '0;
  logic [7:0] in_sustain_in    = '0;
  logic [7:0] in_release_in    = '0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [2:0] out_voice_out;
  logic [7:0] out_level_out;
  logic [1:0] out_phase_out;
  logic       out_voice_active;
  logic       out_last;

  // Requests waiting to be driven, and reports predicted but not yet seen.
  env_request_t  pending_requests[$];
  voice_report_t expected_reports[$];

  int n_requests   = 0;
  int n_accepted   = 0;
  int n_errors     = 0;
  int stuck_cycles = 0;

  // Envelope model state, one entry per voice.
  logic [7:0] env_level   [VOICES];
  logic [1:0] env_phase   [VOICES];
  logic       env_gate    [VOICES];
  logic       env_active  [VOICES];
  logic [7:0] env_attack  [VOICES];
  logic [7:0] env_decay   [VOICES];
  logic [7:0] env_sustain [VOICES];
  logic [7:0] env_release [VOICES];

  adsr_envelope_generator #(
    .VOICES(VOICES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_voice_sel     (in_voice_sel),
    .in_attack_in     (in_attack_in),
    .in_decay_in      (in_decay_in),
    .in_sustain_in    (in_sustain_in),
    .in_release_in    (in_release_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_voice_out    (out_voice_out),
    .out_level_out    (out_level_out),
    .out_phase_out    (out_phase_out),
    .out_voice_active (out_voice_active),
    .out_last         (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Envelope model
  // --------------------------------------------------------------------------

  // Model state after reset: every voice idle, level 0, attack, times zero.
  initial begin
    for (int v = 0; v < VOICES; v++) begin
      env_level[v]   = '0;
      env_phase[v]   = adsr_pkg::PH_ATTACK;
      env_gate[v]    = 1'b0;
      env_active[v]  = 1'b0;
      env_attack[v]  = '0;
      env_decay[v]   = '0;
      env_sustain[v] = '0;
      env_release[v] = '0;
    end
  end

  // One envelope step of a single voice. Arithmetic runs in int so that the
  // signed intermediate values of decay and release behave like the block's
  // integer rules (quotients truncate, rates are floored at 1).
  task automatic step_envelope(input int v);
    int lvl;
    int sus;
    int rate;
    lvl = int'(env_level[v]);
    sus = int'(env_sustain[v]);
    case (env_phase[v])
      adsr_pkg::PH_ATTACK: begin
        if (env_attack[v] == 0) begin
          lvl = int'(adsr_pkg::LEVEL_MAX);
          env_phase[v] = adsr_pkg::PH_DECAY;
        end else begin
          lvl = lvl + int'(adsr_pkg::ATTACK_NUM) / int'(env_attack[v]);
          if (lvl >= int'(adsr_pkg::LEVEL_MAX)) begin
            lvl = int'(adsr_pkg::LEVEL_MAX);
            env_phase[v] = adsr_pkg::PH_DECAY;
          end
        end
      end
      adsr_pkg::PH_DECAY: begin
        if (env_decay[v] == 0) begin
          lvl = sus;
          env_phase[v] = adsr_pkg::PH_SUSTAIN;
        end else begin
          rate = (lvl - sus) / int'(env_decay[v]);
          if (rate < 1) rate = 1;
          lvl = lvl - rate;
          if (lvl <= sus) begin
            lvl = sus;
            env_phase[v] = adsr_pkg::PH_SUSTAIN;
          end
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        // The level holds; a dropped gate moves the voice on to release.
        if (!env_gate[v]) env_phase[v] = adsr_pkg::PH_RELEASE;
      end
      default: begin
        if (env_release[v] == 0) begin
          lvl = 0;
        end else begin
          rate = lvl / int'(env_release[v]);
          if (rate < 1) rate = 1;
          lvl = lvl - rate;
          if (lvl < 0) lvl = 0;
        end
      end
    endcase
    env_level[v] = lvl[7:0];
    // A voice that has released all the way down falls silent.
    if (env_level[v] == 0 && env_phase[v] == adsr_pkg::PH_RELEASE) begin
      env_active[v] = 1'b0;
      env_gate[v]   = 1'b0;
    end
  endtask

  function automatic voice_report_t voice_snapshot(input int v, input logic is_last);
    voice_report_t rep;
    rep.voice  = v[2:0];
    rep.level  = env_level[v];
    rep.phase  = env_phase[v];
    rep.active = env_active[v];
    rep.last   = is_last;
    return rep;
  endfunction

  // Updates the model for one accepted request and queues the voice reports
  // it should produce.
  task automatic predict_voice_reports(input env_request_t req);
    int v;
    int last_voice;
    v = int'(req.voice);
    case (req.cmd)
      adsr_pkg::CMD_TICK: begin
        // Stepping voice i touches no other voice, so the last report goes
        // to the highest voice that is active before the tick.
        last_voice = -1;
        for (int i = 0; i < VOICES; i++)
          if (env_active[i]) last_voice = i;
        for (int i = 0; i < VOICES; i++) begin
          if (env_active[i]) begin
            step_envelope(i);
            expected_reports.push_back(voice_snapshot(i, i == last_voice));
          end
        end
      end
      adsr_pkg::CMD_NOTE_ON: begin
        if (v < VOICES) begin
          env_attack[v]  = req.attack;
          env_decay[v]   = req.decay;
          env_sustain[v] = req.sustain;
          env_release[v] = req.rel_time;
          env_level[v]   = '0;
          env_phase[v]   = adsr_pkg::PH_ATTACK;
          env_gate[v]    = 1'b1;
          env_active[v]  = 1'b1;
          expected_reports.push_back(voice_snapshot(v, 1'b1));
        end
      end
      adsr_pkg::CMD_NOTE_OFF: begin
        // An idle voice takes the gate and phase change but stays idle.
        if (v < VOICES) begin
          env_gate[v]  = 1'b0;
          env_phase[v] = adsr_pkg::PH_RELEASE;
          expected_reports.push_back(voice_snapshot(v, 1'b1));
        end
      end
      default: begin
        // The unused command code changes nothing and reports nothing.
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_request(input logic [1:0] cmd, input int voice,
                               input int attack, input int decay,
                               input int sustain, input int rel_time);
    env_request_t req;
    req.cmd      = cmd;
    req.voice    = voice[2:0];
    req.attack   = attack[7:0];
    req.decay    = decay[7:0];
    req.sustain  = sustain[7:0];
    req.rel_time = rel_time[7:0];
    pending_requests.push_back(req);
  endtask

  // Envelope times lean toward zero and short values so that voices run
  // through all four phases within the run, with the full range still used.
  function automatic int pick_env_time();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(1, 4);
      2:       return $urandom_range(5, 40);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // The idling mode moves on every MODE_SPAN accepted requests, so the
  // directed part runs without gaps and later requests see every mode.
  function automatic int idle_mode();
    return (n_accepted / MODE_SPAN) % 4;
  endfunction

  function automatic int sender_gap_pct();
    case (idle_mode())
      MODE_NONE:   return 0;
      MODE_SENDER: return 85;
      MODE_BOTH:   return 8;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode())
      MODE_RECV: return 85;
      MODE_BOTH: return 8;
      default:   return 0;
    endcase
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      n_errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: a request stays on the in_ ports, unchanged, until the block
  // takes it. Only then, or while nothing is offered, may the next request
  // go out, possibly after a random gap.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    env_request_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        nxt.cmd      = in_cmd;
        nxt.voice    = in_voice_sel;
        nxt.attack   = in_attack_in;
        nxt.decay    = in_decay_in;
        nxt.sustain  = in_sustain_in;
        nxt.rel_time = in_release_in;
        predict_voice_reports(nxt);
        n_accepted <= n_accepted + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_requests.size() != 0 && !chance(sender_gap_pct())) begin
          nxt = pending_requests.pop_front();
          in_valid      <= 1'b1;
          in_cmd        <= nxt.cmd;
          in_voice_sel  <= nxt.voice;
          in_attack_in  <= nxt.attack;
          in_decay_in   <= nxt.decay;
          in_sustain_in <= nxt.sustain;
          in_release_in <= nxt.rel_time;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every report taken from the block is matched against the oldest
  // prediction, field by field. The stall for the next cycle is drawn here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    voice_report_t exp_rep;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report for voice %0d, level %0d", out_voice_out,
                 out_level_out);
          n_errors++;
        end else begin
          exp_rep = expected_reports.pop_front();
          check_field("voice_out", int'(exp_rep.voice), int'(out_voice_out));
          check_field("level_out", int'(exp_rep.level), int'(out_level_out));
          check_field("phase_out", int'(exp_rep.phase), int'(out_phase_out));
          check_field("voice_active", int'(exp_rep.active), int'(out_voice_active));
          check_field("last", int'(exp_rep.last), int'(out_last));
        end
      end
      out_stall <= chance(receiver_stall_pct());
    end
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("adsr_envelope_generator_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n_random;
    int pick;
    n_random = 0;

    // A tick with every voice idle reports nothing, and so does the unused
    // command code, even with every field bit set.
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(CMD_UNUSED, 7, 255, 255, 255, 255);
    // A note off on an idle voice reports it but leaves it out of the ticks.
    queue_request(adsr_pkg::CMD_NOTE_OFF, 5, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    // Instant attack, decay and release on voice 0, full sustain.
    queue_request(adsr_pkg::CMD_NOTE_ON, 0, 0, 0, 255, 0);
    // Slowest possible envelope on voice 7, zero sustain.
    queue_request(adsr_pkg::CMD_NOTE_ON, 7, 255, 255, 0, 255);
    // Time 1 everywhere on voice 3: attack overshoots and is clamped.
    queue_request(adsr_pkg::CMD_NOTE_ON, 3, 1, 1, 128, 1);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_NOTE_OFF, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_NOTE_OFF, 3, 0, 0, 0, 0);
    // Both voices released to 0 on this tick and go idle.
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    // Note off in the middle of the attack; the release rate floors at 1.
    queue_request(adsr_pkg::CMD_NOTE_OFF, 7, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_NOTE_ON, 2, 3, 2, 0, 2);
    // A note on restarts a voice that is still sounding.
    queue_request(adsr_pkg::CMD_NOTE_ON, 7, 0, 255, 100, 4);
    for (int i = 0; i < 5; i++) queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_NOTE_OFF, 2, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);
    queue_request(adsr_pkg::CMD_TICK, 0, 0, 0, 0, 0);

    // Random note traffic. Ticks dominate so that envelopes run their whole
    // course; notes on and off land on random voices in any phase. Fields a
    // command ignores are still randomized so every port bit toggles.
    while (n_random < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_request(adsr_pkg::CMD_NOTE_ON, $urandom_range(0, VOICES - 1),
                      pick_env_time(), pick_env_time(), $urandom_range(0, 255),
                      pick_env_time());
        n_random++;
      end else if (pick < 38) begin
        queue_request(adsr_pkg::CMD_NOTE_OFF, $urandom_range(0, VOICES - 1),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        n_random++;
      end else if (pick < 95) begin
        queue_request(adsr_pkg::CMD_TICK, $urandom_range(0, VOICES - 1),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        n_random++;
      end else begin
        // Ignored by the block, so it does not count toward the random total.
        queue_request(CMD_UNUSED, $urandom_range(0, VOICES - 1),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
    n_requests = pending_requests.size();

    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request is in and every predicted report is out, then
    // give the block time to show any report it should not produce.
    while (n_accepted < n_requests || expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (n_errors == 0 && expected_reports.size() == 0) begin
      $display("adsr_envelope_generator_tb passed");
    end else begin
      $display("adsr_envelope_generator_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/adsr_pkg.sv
rtl/adsr_div.sv
rtl/adsr_vbank.sv
rtl/adsr_envelope_generator.sv
dv/adsr_envelope_generator_tb.sv
